### design/tac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg
// Shared widths, codes, tables and types of the threshold actuator controller.
// ----------------------------------------------------------------------------
package tac_pkg;

	localparam int SENSOR_BITS = 16;
	localparam int NUM_REGS    = 8;
	localparam int REG_IDX_W   = $clog2(NUM_REGS);

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HUMIDITY_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT         = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SOIL          = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WATER_HIGH    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_AIR           = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_RAIN          = 3'd7;

	// Switch bit positions.
	localparam int SW_VENT1 = 0;
	localparam int SW_VENT2 = 1;
	localparam int SW_SKY   = 2;
	localparam int SW_IRR   = 3;
	localparam int SW_FLOOD = 4;
	localparam int SW_HEAT  = 5;
	localparam int SW_WARN  = 6;
	localparam int SW_BUZZ  = 7;

	// Voice command bytes.
	localparam logic [7:0] VC_VENT1_ON  = 8'h01;
	localparam logic [7:0] VC_VENT1_OFF = 8'h02;
	localparam logic [7:0] VC_VENT2_ON  = 8'h03;
	localparam logic [7:0] VC_VENT2_OFF = 8'h04;
	localparam logic [7:0] VC_IRR_ON    = 8'h05;
	localparam logic [7:0] VC_IRR_OFF   = 8'h06;
	localparam logic [7:0] VC_HEAT_ON   = 8'h07;
	localparam logic [7:0] VC_HEAT_OFF  = 8'h08;
	localparam logic [7:0] VC_WARN_ON   = 8'h09;
	localparam logic [7:0] VC_WARN_OFF  = 8'h10;
	localparam logic [7:0] VC_FLOOD_ON  = 8'h11;
	localparam logic [7:0] VC_FLOOD_OFF = 8'h12;
	localparam logic [7:0] VC_BUZZ_ON   = 8'h13;
	localparam logic [7:0] VC_BUZZ_OFF  = 8'h14;
	localparam logic [7:0] VC_SKY_ON    = 8'h15;
	localparam logic [7:0] VC_SKY_OFF   = 8'h16;

	// Candidate announcements of one tick, in emission order.
	localparam int NCAND   = 15;
	localparam int MAX_ANN = 9;
	localparam int CNT_W   = $clog2(MAX_ANN + 1);

	localparam logic [4:0] AN_VENT1_ON   = 5'h01;
	localparam logic [4:0] AN_HEAT_ON    = 5'h02;
	localparam logic [4:0] AN_TEMP_NORM  = 5'h0E;
	localparam logic [4:0] AN_VENT2_ON   = 5'h03;
	localparam logic [4:0] AN_VENT2_OFF  = 5'h10;
	localparam logic [4:0] AN_FLOOD_ON   = 5'h04;
	localparam logic [4:0] AN_FLOOD_OFF  = 5'h14;
	localparam logic [4:0] AN_IRR_ON     = 5'h05;
	localparam logic [4:0] AN_SOIL_WET   = 5'h14;
	localparam logic [4:0] AN_WATER_HIGH = 5'h06;
	localparam logic [4:0] AN_BUZZ_ON    = 5'h07;
	localparam logic [4:0] AN_BUZZ_OFF   = 5'h1A;
	localparam logic [4:0] AN_SKY_ON     = 5'h08;
	localparam logic [4:0] AN_SKY_OFF    = 5'h1C;
	localparam logic [4:0] AN_WARN_OFF   = 5'h18;

	localparam logic [4:0] AUTO_CODE [NCAND] = '{
		AN_VENT1_ON, AN_HEAT_ON, AN_TEMP_NORM, AN_VENT2_ON, AN_VENT2_OFF,
		AN_FLOOD_ON, AN_FLOOD_OFF, AN_IRR_ON, AN_SOIL_WET, AN_WATER_HIGH,
		AN_BUZZ_ON, AN_BUZZ_OFF, AN_SKY_ON, AN_SKY_OFF, AN_WARN_OFF
	};

	// Manual mode: per switch bit, the code for turning on and for turning off.
	localparam logic [4:0] MAN_ON_CODE [8] = '{
		5'h0D, 5'h0F, 5'h1B, 5'h11, 5'h13, 5'h15, 5'h17, 5'h19
	};
	localparam logic [4:0] MAN_OFF_CODE [8] = '{
		5'h0E, 5'h10, 5'h1C, 5'h12, 5'h14, 5'h16, 5'h18, 5'h1A
	};

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Everything the back end needs to play out one tick.
	typedef struct packed {
		logic [NCAND-1:0]       mask;
		logic [NCAND-1:0][4:0]  code;
		logic [NCAND-1:0][7:0]  spoken;
		logic [7:0]             fin_spoken;
		logic [7:0]             switches;
	} tac_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tac_qstat_t;

endpackage

### design/tac_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_in_if
// Control tick channel: sensor samples, mode, voice command and panel write.
// ----------------------------------------------------------------------------
interface tac_in_if;
	logic                            valid;
	logic                            ready;
	logic [tac_pkg::SENSOR_BITS-1:0] temperature;
	logic [tac_pkg::SENSOR_BITS-1:0] humidity;
	logic [tac_pkg::SENSOR_BITS-1:0] illuminance;
	logic [tac_pkg::SENSOR_BITS-1:0] soil_wetness;
	logic [tac_pkg::SENSOR_BITS-1:0] tank_level;
	logic [tac_pkg::SENSOR_BITS-1:0] air_index;
	logic [tac_pkg::SENSOR_BITS-1:0] raindrop;
	logic                            auto_mode;
	logic [7:0]                      voice_command;
	logic                            panel_write;
	logic [7:0]                      panel_switches;

	modport source (
		output valid, temperature, humidity, illuminance, soil_wetness, tank_level,
		output air_index, raindrop, auto_mode, voice_command, panel_write,
		output panel_switches,
		input  ready
	);
	modport sink (
		input  valid, temperature, humidity, illuminance, soil_wetness, tank_level,
		input  air_index, raindrop, auto_mode, voice_command, panel_write,
		input  panel_switches,
		output ready
	);
endinterface

### design/tac_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_out_if
// Result channel: announcements and the closing status item of each tick.
// ----------------------------------------------------------------------------
interface tac_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] voice_code;
	logic [7:0] spoken_value;
	logic [7:0] switches;
	logic       is_announcement;
	logic       is_last;

	modport source (
		output valid, voice_code, spoken_value, switches, is_announcement, is_last,
		input  ready
	);
	modport sink (
		input  valid, voice_code, spoken_value, switches, is_announcement, is_last,
		output ready
	);
endinterface

### design/tac_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_cfg_if
// Threshold register write channel.
// ----------------------------------------------------------------------------
interface tac_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tac_pkg::REG_IDX_W-1:0]   index;
	logic [tac_pkg::SENSOR_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/tac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_front
// Accepts ticks, holds thresholds and switch state, and builds the tick record.
// ----------------------------------------------------------------------------
module tac_front (
	input  logic                clk,
	input  logic                arst_n,
	tac_in_if.sink              in_ch,
	tac_cfg_if.sink             cfg_ch,
	input  tac_pkg::tac_qstat_t qstat,
	output logic                push,
	output tac_pkg::tac_rec_t   rec
);

	logic [tac_pkg::SENSOR_BITS-1:0] temp_high_q, temp_low_q, humidity_high_q, light_q;
	logic [tac_pkg::SENSOR_BITS-1:0] soil_q, water_high_q, air_q, rain_q;
	logic [7:0] sw_q;
	logic [7:0] spk_q;

	logic [7:0] base, vset, vclr, d_voice;
	logic [13:0] fire;
	logic [7:0] asets, aclrs, d_rules, d_auto, d_next;
	logic warn_off;
	logic [7:0] sp0, sp1, sp3, sp5, spk_next;
	logic [7:0] t_lo, h_lo, li_lo;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !qstat.full;
	assign push         = in_ch.valid && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_high_q     <= '0;
			temp_low_q      <= '0;
			humidity_high_q <= '0;
			light_q         <= '0;
			soil_q          <= '0;
			water_high_q    <= '0;
			air_q           <= '0;
			rain_q          <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				tac_pkg::REG_TEMP_HIGH:     temp_high_q     <= cfg_ch.data;
				tac_pkg::REG_TEMP_LOW:      temp_low_q      <= cfg_ch.data;
				tac_pkg::REG_HUMIDITY_HIGH: humidity_high_q <= cfg_ch.data;
				tac_pkg::REG_LIGHT:         light_q         <= cfg_ch.data;
				tac_pkg::REG_SOIL:          soil_q          <= cfg_ch.data;
				tac_pkg::REG_WATER_HIGH:    water_high_q    <= cfg_ch.data;
				tac_pkg::REG_AIR:           air_q           <= cfg_ch.data;
				tac_pkg::REG_RAIN:          rain_q          <= cfg_ch.data;
				default:                    temp_high_q     <= temp_high_q;
			endcase
		end
	end

	// Voice decode into one set or clear bit.
	always_comb begin
		vset = '0;
		vclr = '0;
		unique case (in_ch.voice_command)
			tac_pkg::VC_VENT1_ON:  vset[tac_pkg::SW_VENT1] = 1'b1;
			tac_pkg::VC_VENT1_OFF: vclr[tac_pkg::SW_VENT1] = 1'b1;
			tac_pkg::VC_VENT2_ON:  vset[tac_pkg::SW_VENT2] = 1'b1;
			tac_pkg::VC_VENT2_OFF: vclr[tac_pkg::SW_VENT2] = 1'b1;
			tac_pkg::VC_IRR_ON:    vset[tac_pkg::SW_IRR]   = 1'b1;
			tac_pkg::VC_IRR_OFF:   vclr[tac_pkg::SW_IRR]   = 1'b1;
			tac_pkg::VC_HEAT_ON:   vset[tac_pkg::SW_HEAT]  = 1'b1;
			tac_pkg::VC_HEAT_OFF:  vclr[tac_pkg::SW_HEAT]  = 1'b1;
			tac_pkg::VC_WARN_ON:   vset[tac_pkg::SW_WARN]  = 1'b1;
			tac_pkg::VC_WARN_OFF:  vclr[tac_pkg::SW_WARN]  = 1'b1;
			tac_pkg::VC_FLOOD_ON:  vset[tac_pkg::SW_FLOOD] = 1'b1;
			tac_pkg::VC_FLOOD_OFF: vclr[tac_pkg::SW_FLOOD] = 1'b1;
			tac_pkg::VC_BUZZ_ON:   vset[tac_pkg::SW_BUZZ]  = 1'b1;
			tac_pkg::VC_BUZZ_OFF:  vclr[tac_pkg::SW_BUZZ]  = 1'b1;
			tac_pkg::VC_SKY_ON:    vset[tac_pkg::SW_SKY]   = 1'b1;
			tac_pkg::VC_SKY_OFF:   vclr[tac_pkg::SW_SKY]   = 1'b1;
			default: begin
				vset = '0;
				vclr = '0;
			end
		endcase
	end

	// Unless the panel writes new switches, the saved switches are the desired set at the start of a tick.
	assign base    = in_ch.panel_write ? in_ch.panel_switches : sw_q;
	assign d_voice = (base | vset) & ~vclr;

	always_comb begin
		fire[0]  = (in_ch.temperature > temp_high_q) && !sw_q[tac_pkg::SW_VENT1];
		fire[1]  = (in_ch.temperature < temp_low_q) && !sw_q[tac_pkg::SW_HEAT];
		fire[2]  = (in_ch.temperature < temp_high_q) && (in_ch.temperature > temp_low_q)
			&& (sw_q[tac_pkg::SW_HEAT] || sw_q[tac_pkg::SW_VENT1]);
		fire[3]  = (in_ch.humidity > humidity_high_q) && !sw_q[tac_pkg::SW_VENT2];
		fire[4]  = (in_ch.humidity < humidity_high_q) && sw_q[tac_pkg::SW_VENT2];
		fire[5]  = (in_ch.illuminance < light_q) && !sw_q[tac_pkg::SW_FLOOD];
		fire[6]  = (in_ch.illuminance > light_q) && sw_q[tac_pkg::SW_FLOOD];
		fire[7]  = (in_ch.soil_wetness < soil_q) && !sw_q[tac_pkg::SW_IRR];
		fire[8]  = (in_ch.soil_wetness > soil_q) && sw_q[tac_pkg::SW_IRR];
		fire[9]  = (in_ch.tank_level > water_high_q) && sw_q[tac_pkg::SW_IRR];
		fire[10] = (in_ch.air_index > air_q) && !sw_q[tac_pkg::SW_BUZZ];
		fire[11] = (in_ch.air_index < air_q) && sw_q[tac_pkg::SW_BUZZ];
		fire[12] = (in_ch.raindrop > rain_q) && !sw_q[tac_pkg::SW_SKY];
		fire[13] = (in_ch.raindrop < rain_q) && sw_q[tac_pkg::SW_SKY];
	end

	// No rule sets a bit that another rule of the same tick clears, so the rules
	// reduce to one set mask and one clear mask.
	always_comb begin
		asets = '0;
		aclrs = '0;
		asets[tac_pkg::SW_VENT1] = fire[0];
		asets[tac_pkg::SW_HEAT]  = fire[1];
		aclrs[tac_pkg::SW_VENT1] = fire[2];
		aclrs[tac_pkg::SW_HEAT]  = fire[2];
		asets[tac_pkg::SW_VENT2] = fire[3];
		aclrs[tac_pkg::SW_VENT2] = fire[4];
		asets[tac_pkg::SW_FLOOD] = fire[5];
		aclrs[tac_pkg::SW_FLOOD] = fire[6];
		asets[tac_pkg::SW_IRR]   = fire[7];
		aclrs[tac_pkg::SW_IRR]   = fire[8] || fire[9];
		asets[tac_pkg::SW_BUZZ]  = fire[10];
		aclrs[tac_pkg::SW_BUZZ]  = fire[11];
		asets[tac_pkg::SW_SKY]   = fire[12];
		aclrs[tac_pkg::SW_SKY]   = fire[13];
	end

	assign d_rules  = (d_voice | asets) & ~aclrs;
	assign warn_off = (d_rules & ~(8'(1) << tac_pkg::SW_WARN)) == 8'd0;
	assign d_auto   = warn_off ? (d_rules & ~(8'(1) << tac_pkg::SW_WARN))
		: (d_rules | (8'(1) << tac_pkg::SW_WARN));

	assign t_lo  = in_ch.temperature[7:0];
	assign h_lo  = in_ch.humidity[7:0];
	assign li_lo = in_ch.illuminance[7:0];

	// Spoken byte as each announcement sees it.
	assign sp0 = fire[0] ? t_lo : spk_q;
	assign sp1 = fire[1] ? t_lo : sp0;
	assign sp3 = fire[3] ? h_lo : sp1;
	assign sp5 = fire[5] ? li_lo : sp3;

	assign d_next   = in_ch.auto_mode ? d_auto : d_voice;
	assign spk_next = in_ch.auto_mode ? sp5 : spk_q;

	always_comb begin
		rec            = '0;
		rec.switches   = d_next;
		rec.fin_spoken = spk_next;
		if (in_ch.auto_mode) begin
			rec.mask = {warn_off, fire};
			for (int i = 0; i < tac_pkg::NCAND; i++) begin
				rec.code[i] = tac_pkg::AUTO_CODE[i];
				if (i == 0) begin
					rec.spoken[i] = sp0;
				end else if (i < 3) begin
					rec.spoken[i] = sp1;
				end else if (i < 5) begin
					rec.spoken[i] = sp3;
				end else begin
					rec.spoken[i] = sp5;
				end
			end
		end else begin
			rec.mask[7:0] = d_voice ^ sw_q;
			for (int i = 0; i < 8; i++) begin
				rec.code[i]   = d_voice[i] ? tac_pkg::MAN_ON_CODE[i] : tac_pkg::MAN_OFF_CODE[i];
				rec.spoken[i] = spk_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q  <= '0;
			spk_q <= '0;
		end else if (push) begin
			sw_q  <= d_next;
			spk_q <= spk_next;
		end
	end

endmodule

### design/tac_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_queue
// Short queue of tick records between the front and the back end.
// ----------------------------------------------------------------------------
module tac_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tac_pkg::tac_rec_t   wr_rec,
	input  logic                pop,
	output tac_pkg::tac_rec_t   head,
	output tac_pkg::tac_qstat_t qstat
);

	tac_pkg::tac_rec_t mem_q [tac_pkg::QDEPTH];
	logic [tac_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tac_pkg::QCNT_W-1:0] count_q;

	assign qstat.full  = count_q == tac_pkg::QCNT_W'(tac_pkg::QDEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/tac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_back
// Plays the head record into the output register, one item per cycle if ready.
// ----------------------------------------------------------------------------
module tac_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tac_pkg::tac_rec_t   head,
	input  tac_pkg::tac_qstat_t qstat,
	output logic                pop,
	tac_out_if.source           out_ch
);

	logic [tac_pkg::NCAND-1:0] rem_q;
	logic                      loaded_q;
	logic [tac_pkg::CNT_W-1:0] cnt_q;

	logic                      out_valid_q;
	logic [4:0]                code_q;
	logic [7:0]                spoken_q;
	logic [7:0]                switches_q;
	logic                      ann_q;
	logic                      last_q;

	logic [tac_pkg::NCAND-1:0] eff, low1;
	logic                      emit, has_ann;
	logic [4:0]                sel_code;
	logic [7:0]                sel_spoken;

	assign eff     = loaded_q ? rem_q : head.mask;
	assign low1    = eff & (~eff + 1'b1);
	assign has_ann = (eff != '0) && (cnt_q < tac_pkg::CNT_W'(tac_pkg::MAX_ANN));
	assign emit    = !qstat.empty && (!out_valid_q || out_ch.ready);
	assign pop     = emit && !has_ann;

	always_comb begin
		sel_code   = '0;
		sel_spoken = '0;
		for (int i = 0; i < tac_pkg::NCAND; i++) begin
			sel_code   = sel_code | (low1[i] ? head.code[i] : 5'd0);
			sel_spoken = sel_spoken | (low1[i] ? head.spoken[i] : 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			loaded_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (has_ann) begin
					rem_q    <= eff & ~low1;
					loaded_q <= 1'b1;
					cnt_q    <= cnt_q + 1'b1;
				end else begin
					loaded_q <= 1'b0;
					cnt_q    <= '0;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_q     <= has_ann ? sel_code : 5'd0;
			spoken_q   <= has_ann ? sel_spoken : head.fin_spoken;
			switches_q <= head.switches;
			ann_q      <= has_ann;
			last_q     <= !has_ann;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.voice_code      = code_q;
	assign out_ch.spoken_value    = spoken_q;
	assign out_ch.switches        = switches_q;
	assign out_ch.is_announcement = ann_q;
	assign out_ch.is_last         = last_q;

endmodule

### design/threshold_actuator_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_actuator_controller_top
// Threshold and voice driven switch controller for eight actuators.
//
//   Channel  Dir  Moves                                   Handshake
//   in_ch    in   one control tick (samples, mode, voice)  valid/ready
//   out_ch   out  announcements, then one status item     valid/ready
//   cfg_ch   in   threshold register write                valid/ready
//
// A tick's rules are worked out in the same cycle that the tick is taken.
// The back end sends one item per cycle while out_ch is ready; a tick with
// n announcements sends n + 1 items (1 to 10); the output stage sets the rate.
// Up to two ticks wait in the queue; ready on in_ch drops only when it is full.
// Reset clears the thresholds, the switch set, the spoken byte and the queue.
// ----------------------------------------------------------------------------
module threshold_actuator_controller_top (
	input  logic      clk,
	input  logic      arst_n,
	tac_in_if.sink    in_ch,
	tac_cfg_if.sink   cfg_ch,
	tac_out_if.source out_ch
);

	tac_pkg::tac_rec_t   wr_rec, head;
	tac_pkg::tac_qstat_t qstat;
	logic                push, pop;

	tac_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg_ch (cfg_ch),
		.qstat  (qstat),
		.push   (push),
		.rec    (wr_rec)
	);

	tac_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	tac_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("tick record written into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("tick record retired from an empty queue");

	a_tick_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !qstat.empty)
		else $error("accepted tick did not reach the queue");

	a_ann_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.is_announcement) |-> (out_ch.voice_code != 5'd0 && !out_ch.is_last))
		else $error("announcement item carries no code or closes the tick");

endmodule
